// ===== src/rigid_body_integrator_2d_assert.svh =====
// Assertion macros for the checker file of the rigid body integrator.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef RIGID_BODY_INTEGRATOR_2D_ASSERT_SVH
`define RIGID_BODY_INTEGRATOR_2D_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rigid body integrator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rigid body integrator: next-cycle check failed");

`endif

// ===== src/rbi_pkg.sv =====
package rbi_pkg;

    // Signed Q16.16 value.
    typedef logic signed [31:0] t_q16;

    // Command codes of an input beat.
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_IMPULSE = 2'd0;
    localparam t_cmd CMD_DAMP    = 2'd1;
    localparam t_cmd CMD_TICK    = 2'd2;

    // Micro-operations of the shared multiplier path.
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP = 5'd0;
    localparam t_op OP_FX  = 5'd1;   // force x = impulse x * inverse time step
    localparam t_op OP_FY  = 5'd2;   // force y = impulse y * inverse time step
    localparam t_op OP_TQ2 = 5'd3;   // ry * fx, kept unsaturated
    localparam t_op OP_TQ1 = 5'd4;   // rx * fy, minus the term above
    localparam t_op OP_AX  = 5'd5;   // linear acceleration x accumulation
    localparam t_op OP_AY  = 5'd6;   // linear acceleration y accumulation
    localparam t_op OP_AS  = 5'd7;   // angular acceleration accumulation
    localparam t_op OP_DVX = 5'd8;   // damp velocity x
    localparam t_op OP_DVY = 5'd9;   // damp velocity y
    localparam t_op OP_DSP = 5'd10;  // damp spin
    localparam t_op OP_PX  = 5'd11;  // position x integration
    localparam t_op OP_PY  = 5'd12;  // position y integration
    localparam t_op OP_AN  = 5'd13;  // angle integration
    localparam t_op OP_VX  = 5'd14;  // velocity x integration
    localparam t_op OP_VY  = 5'd15;  // velocity y integration
    localparam t_op OP_SP  = 5'd16;  // spin integration

    typedef logic [3:0] t_step;

    // Configuration register contents.
    typedef struct packed {
        logic [30:0] inverse_mass;
        logic [30:0] inverse_inertia;
        logic [30:0] time_step;
        logic [30:0] inverse_time_step;
        logic [16:0] linear_damping_factor;
        logic [16:0] angular_damping_factor;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        t_op  op;
        logic clear_accel;
        logic snapshot;
    } t_ctrl;

    // Micro-operation issued at a given step of a command. An operation that
    // reads an earlier result is issued only once that result has passed the
    // product, round and write-back stages.
    function automatic t_op sched_op(input t_cmd cmd, input t_step step);
        t_op op;
        op = OP_NOP;
        case (cmd)
            CMD_IMPULSE: begin
                case (step)
                    4'd0:    op = OP_FX;
                    4'd1:    op = OP_FY;
                    4'd3:    op = OP_TQ2;
                    4'd4:    op = OP_TQ1;
                    4'd5:    op = OP_AX;
                    4'd6:    op = OP_AY;
                    4'd7:    op = OP_AS;
                    default: op = OP_NOP;
                endcase
            end
            CMD_DAMP: begin
                case (step)
                    4'd0:    op = OP_DVX;
                    4'd1:    op = OP_DVY;
                    4'd2:    op = OP_DSP;
                    default: op = OP_NOP;
                endcase
            end
            CMD_TICK: begin
                case (step)
                    4'd0:    op = OP_PX;
                    4'd1:    op = OP_PY;
                    4'd2:    op = OP_AN;
                    4'd3:    op = OP_VX;
                    4'd4:    op = OP_VY;
                    4'd5:    op = OP_SP;
                    default: op = OP_NOP;
                endcase
            end
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    // Step at which every write-back of a command has landed.
    function automatic t_step sched_last(input t_cmd cmd);
        t_step last;
        case (cmd)
            CMD_IMPULSE: last = 4'd10;
            CMD_DAMP:    last = 4'd5;
            CMD_TICK:    last = 4'd8;
            default:     last = 4'd0;
        endcase
        return last;
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic t_q16 sat32(input logic signed [48:0] v);
        t_q16 r;
        if ((&v[48:31]) || !(|v[48:31])) begin
            r = v[31:0];
        end else if (v[48]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Saturating addition of two Q16.16 values.
    function automatic t_q16 sadd(input t_q16 a, input t_q16 b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat32({{16{s[32]}}, s});
    endfunction

endpackage

// ===== src/rbi_in_if.sv =====
interface rbi_in_if;
    import rbi_pkg::*;

    logic valid;
    logic ready;
    t_cmd command;
    t_q16 impact_x;
    t_q16 impact_y;
    t_q16 impulse_x;
    t_q16 impulse_y;

    modport source (
        output valid, command, impact_x, impact_y, impulse_x, impulse_y,
        input  ready
    );
    modport sink (
        input  valid, command, impact_x, impact_y, impulse_x, impulse_y,
        output ready
    );
endinterface

// ===== src/rbi_out_if.sv =====
interface rbi_out_if;
    import rbi_pkg::*;

    logic valid;
    logic ready;
    t_q16 position_x;
    t_q16 position_y;
    t_q16 angle;
    t_q16 velocity_x;
    t_q16 velocity_y;
    t_q16 spin_rate;

    modport source (
        output valid, position_x, position_y, angle, velocity_x, velocity_y, spin_rate,
        input  ready
    );
    modport sink (
        input  valid, position_x, position_y, angle, velocity_x, velocity_y, spin_rate,
        output ready
    );
endinterface

// ===== src/rbi_regs.sv =====
module rbi_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rbi_pkg::t_cfg o_cfg
);
    import rbi_pkg::*;

    // Register indexes, at byte address four times the index.
    localparam logic [2:0] REG_INV_MASS    = 3'd0;
    localparam logic [2:0] REG_INV_INERTIA = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_INV_STEP    = 3'd3;
    localparam logic [2:0] REG_LIN_DAMP    = 3'd4;
    localparam logic [2:0] REG_ANG_DAMP    = 3'd5;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_mass           <= 31'd65536;
            r_cfg.inverse_inertia        <= 31'd65536;
            r_cfg.time_step              <= 31'd1092;
            r_cfg.inverse_time_step      <= 31'd3932160;
            r_cfg.linear_damping_factor  <= 17'd0;
            r_cfg.angular_damping_factor <= 17'd0;
        end else if (w_wr) begin
            case (w_idx)
                REG_INV_MASS:    r_cfg.inverse_mass           <= pwdata[30:0];
                REG_INV_INERTIA: r_cfg.inverse_inertia        <= pwdata[30:0];
                REG_TIME_STEP:   r_cfg.time_step              <= pwdata[30:0];
                REG_INV_STEP:    r_cfg.inverse_time_step      <= pwdata[30:0];
                REG_LIN_DAMP:    r_cfg.linear_damping_factor  <= pwdata[16:0];
                REG_ANG_DAMP:    r_cfg.angular_damping_factor <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (w_idx)
            REG_INV_MASS:    prdata = {1'b0, r_cfg.inverse_mass};
            REG_INV_INERTIA: prdata = {1'b0, r_cfg.inverse_inertia};
            REG_TIME_STEP:   prdata = {1'b0, r_cfg.time_step};
            REG_INV_STEP:    prdata = {1'b0, r_cfg.inverse_time_step};
            REG_LIN_DAMP:    prdata = {15'd0, r_cfg.linear_damping_factor};
            REG_ANG_DAMP:    prdata = {15'd0, r_cfg.angular_damping_factor};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== src/rbi_ctrl.sv =====
module rbi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rbi_pkg::t_cmd  i_cmd,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output rbi_pkg::t_ctrl o_ctrl
);
    import rbi_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic  r_state;
    logic  n_state;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    t_step r_step;
    t_step n_step;
    logic  r_out_valid;
    logic  n_out_valid;
    logic  w_out_free;
    logic  w_last;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last      = (r_step == sched_last(r_cmd));
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequencer: step through the schedule of the current command, then
    // hand the state to the output register once it is free.
    always_comb begin
        n_state            = r_state;
        n_cmd              = r_cmd;
        n_step             = r_step;
        o_ctrl.load        = 1'b0;
        o_ctrl.op          = OP_NOP;
        o_ctrl.clear_accel = 1'b0;
        o_ctrl.snapshot    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_cmd       = i_cmd;
                    n_step      = '0;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                o_ctrl.op = sched_op(r_cmd, r_step);
                if (w_last) begin
                    if (w_out_free) begin
                        o_ctrl.snapshot    = 1'b1;
                        o_ctrl.clear_accel = (r_cmd == CMD_TICK);
                        n_state            = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output beat valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctrl.snapshot) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd       <= CMD_IMPULSE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/rbi_dp.sv =====
module rbi_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbi_pkg::t_cfg  i_cfg,
    input  rbi_pkg::t_ctrl i_ctrl,
    input  rbi_pkg::t_q16  i_impact_x,
    input  rbi_pkg::t_q16  i_impact_y,
    input  rbi_pkg::t_q16  i_impulse_x,
    input  rbi_pkg::t_q16  i_impulse_y,
    output rbi_pkg::t_q16  o_position_x,
    output rbi_pkg::t_q16  o_position_y,
    output rbi_pkg::t_q16  o_angle,
    output rbi_pkg::t_q16  o_velocity_x,
    output rbi_pkg::t_q16  o_velocity_y,
    output rbi_pkg::t_q16  o_spin_rate
);
    import rbi_pkg::*;

    // Body state.
    t_q16 r_pos_x, r_pos_y, r_angle;
    t_q16 r_vel_x, r_vel_y, r_spin;
    t_q16 r_acc_x, r_acc_y, r_spin_acc;

    // Captured input beat and intermediate results.
    t_q16 r_rx, r_ry, r_ix, r_iy;
    t_q16 r_fx, r_fy, r_torque;
    logic signed [47:0] r_tmp;

    // Multiplier pipeline.
    t_q16               w_a;
    t_q16               w_b;
    logic signed [63:0] w_prod;
    logic signed [63:0] r_prod;
    logic signed [63:0] w_biased;
    logic signed [47:0] r_rnd;
    t_op                r_op_p;
    t_op                r_op_r;
    t_q16               w_q;
    logic signed [48:0] w_tq;

    // Output register.
    t_q16 r_out_px, r_out_py, r_out_an, r_out_vx, r_out_vy, r_out_sp;

    // Damping multipliers, one minus the clamped factor.
    logic [16:0] w_lin_k;
    logic [16:0] w_ang_k;

    assign w_lin_k = (i_cfg.linear_damping_factor > 17'd65536) ? 17'd0
                   : 17'd65536 - i_cfg.linear_damping_factor;
    assign w_ang_k = (i_cfg.angular_damping_factor > 17'd65536) ? 17'd0
                   : 17'd65536 - i_cfg.angular_damping_factor;

    // Operand selection for the issued micro-operation.
    always_comb begin
        case (i_ctrl.op)
            OP_FX:   begin w_a = r_ix;     w_b = {1'b0, i_cfg.inverse_time_step}; end
            OP_FY:   begin w_a = r_iy;     w_b = {1'b0, i_cfg.inverse_time_step}; end
            OP_TQ2:  begin w_a = r_ry;     w_b = r_fx;                            end
            OP_TQ1:  begin w_a = r_rx;     w_b = r_fy;                            end
            OP_AX:   begin w_a = r_fx;     w_b = {1'b0, i_cfg.inverse_mass};      end
            OP_AY:   begin w_a = r_fy;     w_b = {1'b0, i_cfg.inverse_mass};      end
            OP_AS:   begin w_a = r_torque; w_b = {1'b0, i_cfg.inverse_inertia};   end
            OP_DVX:  begin w_a = r_vel_x;  w_b = {15'd0, w_lin_k};                end
            OP_DVY:  begin w_a = r_vel_y;  w_b = {15'd0, w_lin_k};                end
            OP_DSP:  begin w_a = r_spin;   w_b = {15'd0, w_ang_k};                end
            OP_PX:   begin w_a = r_vel_x;  w_b = {1'b0, i_cfg.time_step};         end
            OP_PY:   begin w_a = r_vel_y;  w_b = {1'b0, i_cfg.time_step};         end
            OP_AN:   begin w_a = r_spin;   w_b = {1'b0, i_cfg.time_step};         end
            OP_VX:   begin w_a = r_acc_x;  w_b = {1'b0, i_cfg.time_step};         end
            OP_VY:   begin w_a = r_acc_y;  w_b = {1'b0, i_cfg.time_step};         end
            OP_SP:   begin w_a = r_spin_acc; w_b = {1'b0, i_cfg.time_step};       end
            default: begin w_a = '0;       w_b = '0;                              end
        endcase
    end

    // Product, then round to nearest with ties upward.
    assign w_prod   = w_a * w_b;
    assign w_biased = r_prod + 64'sd32768;
    assign w_q      = sat32({r_rnd[47], r_rnd});
    assign w_tq     = {r_rnd[47], r_rnd} - {r_tmp[47], r_tmp};

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_rnd  <= w_biased[63:16];
    end

    // Operation tags follow the data through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_p <= OP_NOP;
            r_op_r <= OP_NOP;
        end else begin
            r_op_p <= i_ctrl.op;
            r_op_r <= r_op_p;
        end
    end

    // Input capture and intermediate write-back.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rx <= i_impact_x;
            r_ry <= i_impact_y;
            r_ix <= i_impulse_x;
            r_iy <= i_impulse_y;
        end
        case (r_op_r)
            OP_FX:   r_fx     <= w_q;
            OP_FY:   r_fy     <= w_q;
            OP_TQ2:  r_tmp    <= r_rnd;
            OP_TQ1:  r_torque <= sat32(w_tq);
            default: ;
        endcase
    end

    // Body state write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_angle    <= '0;
            r_vel_x    <= '0;
            r_vel_y    <= '0;
            r_spin     <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_spin_acc <= '0;
        end else begin
            case (r_op_r)
                OP_AX:   r_acc_x    <= sadd(r_acc_x, w_q);
                OP_AY:   r_acc_y    <= sadd(r_acc_y, w_q);
                OP_AS:   r_spin_acc <= sadd(r_spin_acc, w_q);
                OP_DVX:  r_vel_x    <= w_q;
                OP_DVY:  r_vel_y    <= w_q;
                OP_DSP:  r_spin     <= w_q;
                OP_PX:   r_pos_x    <= sadd(r_pos_x, w_q);
                OP_PY:   r_pos_y    <= sadd(r_pos_y, w_q);
                OP_AN:   r_angle    <= sadd(r_angle, w_q);
                OP_VX:   r_vel_x    <= sadd(r_vel_x, w_q);
                OP_VY:   r_vel_y    <= sadd(r_vel_y, w_q);
                OP_SP:   r_spin     <= sadd(r_spin, w_q);
                default: ;
            endcase
            if (i_ctrl.clear_accel) begin
                r_acc_x    <= '0;
                r_acc_y    <= '0;
                r_spin_acc <= '0;
            end
        end
    end

    // Output register, loaded once all write-backs of an item have landed.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.snapshot) begin
            r_out_px <= r_pos_x;
            r_out_py <= r_pos_y;
            r_out_an <= r_angle;
            r_out_vx <= r_vel_x;
            r_out_vy <= r_vel_y;
            r_out_sp <= r_spin;
        end
    end

    assign o_position_x = r_out_px;
    assign o_position_y = r_out_py;
    assign o_angle      = r_out_an;
    assign o_velocity_x = r_out_vx;
    assign o_velocity_y = r_out_vy;
    assign o_spin_rate  = r_out_sp;

endmodule

// ===== src/rigid_body_integrator_2d.sv =====
// Channel   Direction  Beat contents
// i_in      sink       command, impact_x, impact_y, impulse_x, impulse_y
// o_out     source     position_x, position_y, angle, velocity_x, velocity_y, spin_rate
// apb       slave      six registers at byte addresses 0x00 to 0x14
//
// One input beat at a time: the next beat is accepted only after the result of
// the last one has been handed to the output register, and the hand-over waits
// while a full output register drains. All arithmetic runs on the single shared
// 32x32 multiplier and its three-stage product, round and write-back path.
// Reset is synchronous, active low; it zeroes the body state and loads the
// register defaults.
module rigid_body_integrator_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbi_in_if.sink      i_in,
    rbi_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbi_pkg::*;

    t_cfg  w_cfg;
    t_ctrl w_ctrl;

    // Configuration registers.
    rbi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    rbi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_cmd       (i_in.command),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctrl      (w_ctrl)
    );

    // Arithmetic and body state.
    rbi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_ctrl       (w_ctrl),
        .i_impact_x   (i_in.impact_x),
        .i_impact_y   (i_in.impact_y),
        .i_impulse_x  (i_in.impulse_x),
        .i_impulse_y  (i_in.impulse_y),
        .o_position_x (o_out.position_x),
        .o_position_y (o_out.position_y),
        .o_angle      (o_out.angle),
        .o_velocity_x (o_out.velocity_x),
        .o_velocity_y (o_out.velocity_y),
        .o_spin_rate  (o_out.spin_rate)
    );

endmodule

// ===== src/rbi_checker.sv =====
`include "rigid_body_integrator_2d_assert.svh"

module rbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_position_x,
    input logic [31:0] i_angle,
    input logic [31:0] i_spin_rate,
    input logic        i_pready
);

    // Watched part of the output beat, gathered into one word.
    logic [95:0] w_payload;

    assign w_payload = {i_position_x, i_angle, i_spin_rate};

    // A stalled output beat stays offered.
    `RBI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled output beat keeps its payload.
    `RBI_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(w_payload))

    // Only one item is in work: an accepted beat closes the input side.
    `RBI_ASSERT_NEXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready)

    // No result can appear in the cycle right after an input beat, and the register port is ready then.
    `RBI_ASSERT_SAME(a_min_latency, $past(i_in_valid && i_in_ready), !$rose(i_out_valid) && i_pready)

endmodule

bind rigid_body_integrator_2d rbi_checker u_rbi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_position_x (o_out.position_x),
    .i_angle      (o_out.angle),
    .i_spin_rate  (o_out.spin_rate),
    .i_pready     (pready)
);
